### hw/rtl/tfc_pkg.sv
// Package for the timer frequency calibrator: payload and configuration types,
// command and status codes, register indexes and fixed field widths.
// No dependencies.
package tfc_pkg;

    localparam int STAMP_FIELD_BITS = 64;
    localparam int FREQ_BITS        = 64;
    localparam int REF_HZ_BITS      = 40;
    localparam int CYCLES_BITS      = 32;
    localparam int MIN_SAMPLES_BITS = 16;
    localparam int SPREAD_BITS      = 8;
    localparam int PRODUCT_BITS     = CYCLES_BITS + REF_HZ_BITS;
    localparam int CFG_DATA_BITS    = 40;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int DIV_COUNT_BITS   = $clog2(FREQ_BITS);
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_REFERENCE_HZ   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNTED_CYCLES = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SAMPLES    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPREAD_FACTOR  = 2'd3;

    localparam logic [REF_HZ_BITS-1:0]      RESET_REFERENCE_HZ   = 40'd0;
    localparam logic [CYCLES_BITS-1:0]      RESET_COUNTED_CYCLES = 32'd500000;
    localparam logic [MIN_SAMPLES_BITS-1:0] RESET_MIN_SAMPLES    = 16'd1;
    localparam logic [SPREAD_BITS-1:0]      RESET_SPREAD_FACTOR  = 8'd10;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FINISH = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FEW_SAMPLES  = 2'd1,
        ST_SPREAD       = 2'd2,
        ST_ZERO_ELAPSED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_SAT,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        t_command                    command;
        logic [STAMP_FIELD_BITS-1:0] stamp;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [FREQ_BITS-1:0] frequency_hz;
    } t_out_item;

    typedef struct packed {
        logic [REF_HZ_BITS-1:0]      reference_hz;
        logic [CYCLES_BITS-1:0]      counted_cycles;
        logic [MIN_SAMPLES_BITS-1:0] min_samples;
        logic [SPREAD_BITS-1:0]      spread_factor;
    } t_cfg;

endpackage

### hw/rtl/tfc_front.sv
// Front end of the calibrator: accepts requests, tracks stamps and gaps,
// and hands a snapshot of the run to the job queue on finish. Uses tfc_pkg.
module tfc_front import tfc_pkg::*; #(
    parameter int STAMP_BITS = 64,
    parameter int COUNT_BITS = 32,
    parameter int JOB_BITS   = 3 * STAMP_BITS + COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_in_item            i_in,
    output logic                o_stall,
    input  logic                i_queue_full,
    output logic                o_push,
    output logic [JOB_BITS-1:0] o_job
);

    logic [STAMP_BITS-1:0] r_first;
    logic [STAMP_BITS-1:0] r_prev;
    logic [STAMP_BITS-1:0] r_smallest;
    logic [STAMP_BITS-1:0] r_largest;
    logic [COUNT_BITS-1:0] r_count;

    logic                  w_accept;
    logic [STAMP_BITS-1:0] w_stamp;
    logic [STAMP_BITS-1:0] w_gap;
    logic [STAMP_BITS-1:0] w_elapsed;

    assign o_stall   = i_queue_full;
    assign w_accept  = i_valid && !i_queue_full;
    assign w_stamp   = i_in.stamp[STAMP_BITS-1:0];
    assign w_gap     = w_stamp - r_prev;
    assign w_elapsed = r_prev - r_first;
    assign o_push    = w_accept && (i_in.command == CMD_FINISH);
    assign o_job     = {r_largest, r_smallest, r_count, w_elapsed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_prev     <= '0;
            r_smallest <= '1;
            r_largest  <= '0;
            r_count    <= '0;
        end else if (w_accept) begin
            case (i_in.command)
                CMD_START: begin
                    r_first    <= w_stamp;
                    r_prev     <= w_stamp;
                    r_smallest <= '1;
                    r_largest  <= '0;
                    r_count    <= '0;
                end
                CMD_SAMPLE: begin
                    if (w_gap < r_smallest) begin
                        r_smallest <= w_gap;
                    end
                    if (w_gap > r_largest) begin
                        r_largest <= w_gap;
                    end
                    r_prev <= w_stamp;
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                    // Finish leaves the tracking as it is; the unused code is dropped.
                end
            endcase
        end
    end

endmodule

### hw/rtl/tfc_queue.sv
// Short job queue between the front end and the back end of the calibrator.
// Uses tfc_pkg for its depth.
module tfc_queue import tfc_pkg::*; #(
    parameter int WIDTH = 224
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/tfc_back.sv
// Back end of the calibrator: checks a finished run, forms the frequency by
// a multiply and a one-bit-per-cycle division, and holds the result. Uses tfc_pkg.
module tfc_back import tfc_pkg::*; #(
    parameter int STAMP_BITS = 64,
    parameter int COUNT_BITS = 32,
    parameter int JOB_BITS   = 3 * STAMP_BITS + COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_job_valid,
    input  logic [JOB_BITS-1:0] i_job,
    output logic                o_pop,
    output logic                o_valid,
    output t_out_item           o_out,
    input  logic                i_stall
);

    localparam int CMP_BITS    = (COUNT_BITS > MIN_SAMPLES_BITS) ? COUNT_BITS : MIN_SAMPLES_BITS;
    localparam int SPREAD_PROD = STAMP_BITS + SPREAD_BITS;

    t_back_state r_state, n_state;

    logic [STAMP_BITS-1:0]     r_largest, n_largest;
    logic [STAMP_BITS-1:0]     r_smallest, n_smallest;
    logic [COUNT_BITS-1:0]     r_count, n_count;
    logic [STAMP_BITS-1:0]     r_elapsed, n_elapsed;
    logic [PRODUCT_BITS-1:0]   r_acc, n_acc;
    logic [STAMP_BITS-1:0]     r_rem, n_rem;
    logic [FREQ_BITS-1:0]      r_lo, n_lo;
    logic [FREQ_BITS-1:0]      r_freq, n_freq;
    logic [DIV_COUNT_BITS-1:0] r_bit, n_bit;
    t_status                   r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    logic [SPREAD_PROD-1:0]             w_spread_limit;
    logic [2*CYCLES_BITS-1:0]           w_prod_lo;
    logic [CYCLES_BITS+SPREAD_BITS-1:0] w_prod_hi;
    logic [STAMP_BITS:0]                w_shifted;
    logic                               w_fits;

    assign w_spread_limit = SPREAD_PROD'(r_smallest) * SPREAD_PROD'(i_cfg.spread_factor);
    assign w_prod_lo = (2*CYCLES_BITS)'(i_cfg.counted_cycles)
                     * (2*CYCLES_BITS)'(i_cfg.reference_hz[CYCLES_BITS-1:0]);
    assign w_prod_hi = (CYCLES_BITS+SPREAD_BITS)'(i_cfg.counted_cycles)
                     * (CYCLES_BITS+SPREAD_BITS)'(i_cfg.reference_hz[REF_HZ_BITS-1:CYCLES_BITS]);
    assign w_shifted = {r_rem, r_lo[FREQ_BITS-1]};
    assign w_fits    = (w_shifted >= {1'b0, r_elapsed});

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_largest  <= n_largest;
        r_smallest <= n_smallest;
        r_count    <= n_count;
        r_elapsed  <= n_elapsed;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_freq     <= n_freq;
        r_bit      <= n_bit;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_largest   = r_largest;
        n_smallest  = r_smallest;
        n_count     = r_count;
        n_elapsed   = r_elapsed;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_lo        = r_lo;
        n_freq      = r_freq;
        n_bit       = r_bit;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    {n_largest, n_smallest, n_count, n_elapsed} = i_job;
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                n_freq = '0;
                if (CMP_BITS'(r_count) < CMP_BITS'(i_cfg.min_samples)) begin
                    n_status = ST_FEW_SAMPLES;
                    n_state  = BK_DONE;
                end else if (SPREAD_PROD'(r_largest) > w_spread_limit) begin
                    n_status = ST_SPREAD;
                    n_state  = BK_DONE;
                end else if (r_elapsed == '0) begin
                    n_status = ST_ZERO_ELAPSED;
                    n_state  = BK_DONE;
                end else begin
                    n_status = ST_OK;
                    n_state  = BK_MUL_LO;
                end
            end
            BK_MUL_LO: begin
                n_acc   = PRODUCT_BITS'(w_prod_lo);
                n_state = BK_MUL_HI;
            end
            BK_MUL_HI: begin
                n_acc   = r_acc + (PRODUCT_BITS'(w_prod_hi) << CYCLES_BITS);
                n_state = BK_SAT;
            end
            BK_SAT: begin
                if (STAMP_BITS'(r_acc[PRODUCT_BITS-1:FREQ_BITS]) >= r_elapsed) begin
                    n_freq  = '1;
                    n_state = BK_DONE;
                end else begin
                    n_rem   = STAMP_BITS'(r_acc[PRODUCT_BITS-1:FREQ_BITS]);
                    n_lo    = r_acc[FREQ_BITS-1:0];
                    n_freq  = '0;
                    n_bit   = '1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (w_fits) begin
                    n_rem = STAMP_BITS'(w_shifted - {1'b0, r_elapsed});
                end else begin
                    n_rem = w_shifted[STAMP_BITS-1:0];
                end
                n_freq = {r_freq[FREQ_BITS-2:0], w_fits};
                n_lo   = {r_lo[FREQ_BITS-2:0], 1'b0};
                n_bit  = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.status       = r_status;
                    n_out.frequency_hz = r_freq;
                    n_out_valid        = 1'b1;
                    n_state            = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/timer_frequency_calibrator_unit.sv
// Timer frequency calibrator, top level: configuration registers, front end,
// job queue and back end. Uses tfc_pkg, tfc_front, tfc_queue and tfc_back.
//
// Input channel (i_valid, i_in, o_stall) carries start, sample and finish
// requests; a request is taken at a clock edge with i_valid high and o_stall
// low. Start and sample requests update the gap tracking in the front end at
// one request per cycle while o_stall is low and produce no result. A
// finish request takes a snapshot of the run and places it in a two-entry job
// queue; o_stall rises only while that queue is full. Unused command codes are
// dropped. The back end checks each queued run and, when it passes, computes
// counted_cycles * reference_hz / elapsed with a two-step multiply and a
// restoring divider that retires one quotient bit per cycle. A finish result
// comes straight from the checks when one fails, from the saturation step when
// the quotient saturates, and from the divider for a full answer.
// Output channel (o_valid, o_out, i_stall) is a single output register: the
// back end waits in its final state while a held result is stalled, and the
// front end keeps taking samples meanwhile. Configuration is written through
// i_cfg_we, i_cfg_index and i_cfg_data, by the user only while idle; the block
// does not enforce this. Synchronous active-low reset restores the register
// defaults, clears the tracking state, empties the queue and drops any result.
module timer_frequency_calibrator_unit import tfc_pkg::*; #(
    parameter int STAMP_BITS = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_in_item                  i_in,
    output logic                      o_stall,
    output logic                      o_valid,
    output t_out_item                 o_out,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int JOB_BITS = 3 * STAMP_BITS + COUNT_BITS;

    // Configuration registers; the back end reads them directly, so the user
    // must change them only while no run is in flight; nothing enforces it.
    t_cfg r_cfg;

    logic                w_queue_full;
    logic                w_push;
    logic [JOB_BITS-1:0] w_push_job;
    logic                w_pop;
    logic                w_job_valid;
    logic [JOB_BITS-1:0] w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_hz   <= RESET_REFERENCE_HZ;
            r_cfg.counted_cycles <= RESET_COUNTED_CYCLES;
            r_cfg.min_samples    <= RESET_MIN_SAMPLES;
            r_cfg.spread_factor  <= RESET_SPREAD_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REFERENCE_HZ:   r_cfg.reference_hz   <= i_cfg_data[REF_HZ_BITS-1:0];
                CFG_COUNTED_CYCLES: r_cfg.counted_cycles <= i_cfg_data[CYCLES_BITS-1:0];
                CFG_MIN_SAMPLES:    r_cfg.min_samples    <= i_cfg_data[MIN_SAMPLES_BITS-1:0];
                CFG_SPREAD_FACTOR:  r_cfg.spread_factor  <= i_cfg_data[SPREAD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: gap tracking and classification of each request.
    tfc_front #(
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in         (i_in),
        .o_stall      (o_stall),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // Finished runs wait here so sampling stalls only while the queue is full.
    tfc_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_job)
    );

    // Back end: checks, multiply, divide and the output register.
    tfc_back #(
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_stall     (i_stall)
    );

endmodule
